### hdl/format_stream_int_to_ascii_unit_macros.svh
// Assertion shorthands shared by the checker.
// Both expect i_clk and i_rst_n in scope.
`ifndef FORMAT_STREAM_INT_TO_ASCII_UNIT_MACROS_SVH
`define FORMAT_STREAM_INT_TO_ASCII_UNIT_MACROS_SVH

// same-cycle implication
`define FSIA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FSIA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/fsia_pkg.sv
`default_nettype none
package fsia_pkg;

    localparam int ARG_WIDTH_DEF = 32;
    // decimal digits of the largest magnitude, one spare at most
    localparam int DEC_DIG_DEF = (ARG_WIDTH_DEF * 77) / 256 + 1;

    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_ARG  = 1'b1;

    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_DEC  = 2'd1;
    localparam logic [1:0] PEND_HEX  = 2'd2;
    localparam logic [1:0] PEND_BIN  = 2'd3;

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_X     = 8'h78;

    typedef struct packed {
        logic               operation;
        logic [7:0]         format_char;
        logic signed [31:0] argument_value;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
    } t_out_word;

    typedef struct packed {
        logic       load;
        logic [1:0] kind;
    } t_emit_cmd;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        case (nib)
            4'h0: c = 8'h30;
            4'h1: c = 8'h31;
            4'h2: c = 8'h32;
            4'h3: c = 8'h33;
            4'h4: c = 8'h34;
            4'h5: c = 8'h35;
            4'h6: c = 8'h36;
            4'h7: c = 8'h37;
            4'h8: c = 8'h38;
            4'h9: c = 8'h39;
            4'hA: c = 8'h41;
            4'hB: c = 8'h42;
            4'hC: c = 8'h43;
            4'hD: c = 8'h44;
            4'hE: c = 8'h45;
            default: c = 8'h46;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

### hdl/fsia_bcd.sv
`default_nettype none
// Shift-and-add-3 binary to BCD, one bit per cycle.
module fsia_bcd #(
    parameter int ARG_WIDTH = fsia_pkg::ARG_WIDTH_DEF,
    parameter int DEC_DIG   = fsia_pkg::DEC_DIG_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [ARG_WIDTH-1:0]   i_bin,
    output logic                        o_done,
    output logic [4*DEC_DIG-1:0]        o_bcd
);
    localparam int CNT_W = $clog2(ARG_WIDTH + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [ARG_WIDTH-1:0] r_bin;
    logic [4*DEC_DIG-1:0] r_bcd;
    logic [4*DEC_DIG-1:0] w_adj;

    always_comb begin
        for (int i = 0; i < DEC_DIG; i++) begin
            w_adj[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd5) ? r_bcd[4*i +: 4] + 4'd3
                                                         : r_bcd[4*i +: 4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bin <= i_bin;
            r_bcd <= '0;
            r_cnt <= CNT_W'(ARG_WIDTH);
        end else if (r_busy) begin
            r_bcd <= {w_adj[4*DEC_DIG-2:0], r_bin[ARG_WIDTH-1]};
            r_bin <= r_bin << 1;
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;
endmodule
`default_nettype wire

### hdl/fsia_emit.sv
`default_nettype none
// Digit shifter: one character per cycle while i_free is high, from the top of a shift register.
module fsia_emit #(
    parameter int ARG_WIDTH = fsia_pkg::ARG_WIDTH_DEF,
    parameter int DEC_DIG   = fsia_pkg::DEC_DIG_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire fsia_pkg::t_emit_cmd    i_cmd,
    input  wire logic [ARG_WIDTH-1:0]   i_value,
    input  wire logic [4*DEC_DIG-1:0]   i_bcd,
    input  wire logic                   i_free,
    output logic                        o_busy,
    output logic                        o_valid,
    output fsia_pkg::t_out_word         o_word
);
    localparam int HEX_DIG = (ARG_WIDTH + 3) / 4;
    localparam int SR_W    = (DEC_DIG > HEX_DIG) ? 4 * DEC_DIG : 4 * HEX_DIG;
    localparam int CNT_W   = $clog2(ARG_WIDTH + 1);

    logic             r_busy;
    logic [1:0]       r_kind;
    logic             r_lead;
    logic [CNT_W-1:0] r_cnt;
    logic [SR_W-1:0]  r_sr;

    logic [3:0] w_nib;
    logic       w_last;
    logic       w_skip;
    logic       w_step;

    assign w_nib  = r_sr[SR_W-1 -: 4];
    assign w_last = (r_cnt == CNT_W'(1));
    // decimal leading zeros are dropped, the units digit always goes out
    assign w_skip = r_busy && r_kind == fsia_pkg::PEND_DEC && r_lead
                    && w_nib == 4'd0 && !w_last;

    assign o_busy  = r_busy;
    assign o_valid = r_busy && !w_skip;
    assign w_step  = w_skip || (o_valid && i_free);

    always_comb begin
        o_word.last = w_last;
        if (r_kind == fsia_pkg::PEND_BIN) begin
            o_word.out_char = r_sr[SR_W-1] ? fsia_pkg::CH_ONE : fsia_pkg::CH_ZERO;
        end else begin
            o_word.out_char = fsia_pkg::hex_char(w_nib);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_cmd.load) begin
            r_busy <= 1'b1;
        end else if (w_step && w_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_cmd.kind;
            r_lead <= 1'b1;
            unique case (i_cmd.kind)
                fsia_pkg::PEND_DEC: begin
                    r_sr  <= SR_W'(i_bcd) << (SR_W - 4 * DEC_DIG);
                    r_cnt <= CNT_W'(DEC_DIG);
                end
                fsia_pkg::PEND_HEX: begin
                    r_sr  <= SR_W'(i_value) << (SR_W - 4 * HEX_DIG);
                    r_cnt <= CNT_W'(HEX_DIG);
                end
                default: begin
                    r_sr  <= SR_W'(i_value) << (SR_W - ARG_WIDTH);
                    r_cnt <= CNT_W'(ARG_WIDTH);
                end
            endcase
        end else if (w_step) begin
            r_sr  <= (r_kind == fsia_pkg::PEND_BIN) ? r_sr << 1 : r_sr << 4;
            r_cnt <= r_cnt - 1'b1;
            if (w_nib != 4'd0) begin
                r_lead <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

### hdl/format_stream_int_to_ascii_unit.sv
// A character word or a '-' sign is valid on o_out_word in the cycle after accept;
// the first %x or %b digit passes the emit shift register, then the output register;
// a %d argument first waits for the BCD converter. Digits follow one per cycle while the
// output is free; leading zero slots of %d are dropped. Without output stall, words with no
// conversion go back to back; an argument stalls the input until its last digit is out.
// Reset (i_rst_n low, synchronous) clears state, escape, pending kind and output valid.
`default_nettype none
module format_stream_int_to_ascii_unit #(
    parameter int ARG_WIDTH = fsia_pkg::ARG_WIDTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire fsia_pkg::t_in_word i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output fsia_pkg::t_out_word     o_out_word
);
    localparam int DEC_DIG = (ARG_WIDTH * 77) / 256 + 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]          r_state, n_state;
    logic                r_escape, n_escape;
    logic [1:0]          r_pend, n_pend;
    logic                r_out_valid;
    fsia_pkg::t_out_word r_out_word;

    logic                 w_free;
    logic                 w_accept;
    logic                 w_wr;
    fsia_pkg::t_out_word  w_word;
    logic [63:0]          w_ext;
    logic [ARG_WIDTH-1:0] w_arg;
    logic [ARG_WIDTH-1:0] w_mag;
    logic                 w_bcd_start;
    logic                 w_bcd_done;
    logic [4*DEC_DIG-1:0] w_bcd;
    fsia_pkg::t_emit_cmd  w_cmd;
    logic                 w_emit_busy;
    logic                 w_emit_valid;
    fsia_pkg::t_out_word  w_emit_word;

    assign w_free     = !r_out_valid || !i_out_stall;
    assign o_in_stall = !(r_state == ST_IDLE && w_free);
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_ext = {{32{i_in_word.argument_value[31]}}, i_in_word.argument_value};
    assign w_arg = w_ext[ARG_WIDTH-1:0];
    assign w_mag = w_arg[ARG_WIDTH-1] ? (~w_arg + 1'b1) : w_arg;

    always_comb begin
        n_state     = r_state;
        n_escape    = r_escape;
        n_pend      = r_pend;
        w_wr        = 1'b0;
        w_word      = '{out_char: i_in_word.format_char, last: 1'b1};
        w_bcd_start = 1'b0;
        w_cmd       = '{load: 1'b0, kind: r_pend};
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_in_word.operation == fsia_pkg::OP_ARG) begin
                        if (r_pend != fsia_pkg::PEND_NONE) begin
                            n_pend = fsia_pkg::PEND_NONE;
                            if (r_pend == fsia_pkg::PEND_DEC) begin
                                w_bcd_start = 1'b1;
                                n_state     = ST_CONV;
                                if (w_arg[ARG_WIDTH-1]) begin
                                    w_wr   = 1'b1;
                                    w_word = '{out_char: fsia_pkg::CH_MINUS, last: 1'b0};
                                end
                            end else begin
                                w_cmd.load = 1'b1;
                                n_state    = ST_EMIT;
                            end
                        end
                    end else if (r_escape) begin
                        n_escape = 1'b0;
                        unique case (i_in_word.format_char)
                            fsia_pkg::CH_PCT: w_wr   = 1'b1;
                            fsia_pkg::CH_D:   n_pend = fsia_pkg::PEND_DEC;
                            fsia_pkg::CH_X:   n_pend = fsia_pkg::PEND_HEX;
                            fsia_pkg::CH_B:   n_pend = fsia_pkg::PEND_BIN;
                            default: ;
                        endcase
                    end else if (i_in_word.format_char == fsia_pkg::CH_PCT) begin
                        n_escape = 1'b1;
                    end else begin
                        w_wr = 1'b1;
                    end
                end
            end
            ST_CONV: begin
                if (w_bcd_done) begin
                    w_cmd   = '{load: 1'b1, kind: fsia_pkg::PEND_DEC};
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!w_emit_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        if (w_emit_valid && w_free) begin
            w_wr   = 1'b1;
            w_word = w_emit_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_escape    <= 1'b0;
            r_pend      <= fsia_pkg::PEND_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_escape <= n_escape;
            r_pend   <= n_pend;
            if (w_wr) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_out_word <= w_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    fsia_bcd #(
        .ARG_WIDTH (ARG_WIDTH),
        .DEC_DIG   (DEC_DIG)
    ) u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_bcd_start),
        .i_bin   (w_mag),
        .o_done  (w_bcd_done),
        .o_bcd   (w_bcd)
    );

    fsia_emit #(
        .ARG_WIDTH (ARG_WIDTH),
        .DEC_DIG   (DEC_DIG)
    ) u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_value (w_arg),
        .i_bcd   (w_bcd),
        .i_free  (w_free),
        .o_busy  (w_emit_busy),
        .o_valid (w_emit_valid),
        .o_word  (w_emit_word)
    );
endmodule
`default_nettype wire

### hdl/fsia_checker.sv
`default_nettype none
`include "format_stream_int_to_ascii_unit_macros.svh"
module fsia_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_stall,
    input wire fsia_pkg::t_in_word  i_in_word,
    input wire logic                o_out_valid,
    input wire logic                i_out_stall,
    input wire fsia_pkg::t_out_word o_out_word
);
    logic [7:0] w_c;
    logic       w_mid_ok;
    assign w_c = o_out_word.out_char;
    // only a sign or a digit can be followed by more of the same item
    assign w_mid_ok = (w_c == fsia_pkg::CH_MINUS)
                      || (w_c >= fsia_pkg::CH_ZERO && w_c <= fsia_pkg::CH_NINE)
                      || (w_c >= fsia_pkg::CH_UA && w_c <= fsia_pkg::CH_UF);

    `FSIA_ASSERT_NXT(a_valid_hold, o_out_valid && i_out_stall, o_out_valid, "out word dropped")
    `FSIA_ASSERT_NXT(a_word_hold, o_out_valid && i_out_stall, $stable(o_out_word), "out word changed")
    // a full, stalled output slot must block new input words
    `FSIA_ASSERT_IMP(a_in_blocked, o_out_valid && i_out_stall, o_in_stall, "input taken while full")
    `FSIA_ASSERT_IMP(a_mid_char, o_out_valid && !o_out_word.last, w_mid_ok, "bad non-final char")
    `FSIA_ASSERT_NXT(a_in_hold, i_in_valid && o_in_stall, i_in_valid && $stable(i_in_word), "in word changed")
endmodule

bind format_stream_int_to_ascii_unit fsia_checker u_fsia_checker (.*);
`default_nettype wire
